[design/sparse_coo_matrix_add_unit_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the sparse COO matrix add unit
// Each macro wraps a clocked concurrent assertion on clk.
// ----------------------------------------------------------------------------
`ifndef SPARSE_COO_MATRIX_ADD_UNIT_ASSERT_SVH
`define SPARSE_COO_MATRIX_ADD_UNIT_ASSERT_SVH

// Checked only while out of reset.
`define SCMA_ASSERT_RUN(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define SCMA_ASSERT_ALL(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/scma_pkg.sv]
// ----------------------------------------------------------------------------
// scma_pkg
// Shared types, constants and operation codes of the sparse COO matrix adder.
// ----------------------------------------------------------------------------
package scma_pkg;

  localparam int INDEX_BITS          = 10;
  localparam int VALUE_BITS          = 32;
  localparam int DEFAULT_MAX_ENTRIES = 256;
  localparam int OP_BITS             = 2;
  localparam int ENTRY_BITS          = 2 * INDEX_BITS + VALUE_BITS;
  localparam int TDATA_BITS          = ((ENTRY_BITS + 7) / 8) * 8;
  localparam int IN_TUSER_BITS       = OP_BITS;
  localparam int OUT_TUSER_BITS      = 2;

  localparam logic [OP_BITS-1:0] OP_CLEAR    = 2'd0;
  localparam logic [OP_BITS-1:0] OP_APPEND_A = 2'd1;
  localparam logic [OP_BITS-1:0] OP_APPEND_B = 2'd2;
  localparam logic [OP_BITS-1:0] OP_PULL     = 2'd3;

  typedef struct packed {
    logic [INDEX_BITS-1:0] row;
    logic [INDEX_BITS-1:0] col;
    logic [VALUE_BITS-1:0] value;
  } scma_entry_t;

  // Outcome of one merge step
  typedef struct packed {
    logic        take_a;
    logic        take_b;
    logic        valid_res;
    logic        overflow;
    scma_entry_t entry;
  } scma_pick_t;

endpackage

[design/scma_list_mem.sv]
// ----------------------------------------------------------------------------
// scma_list_mem
// One coordinate list: single write port, single read port, registered read.
// ----------------------------------------------------------------------------
module scma_list_mem
  import scma_pkg::*;
#(
  parameter int DEPTH = DEFAULT_MAX_ENTRIES,
  parameter int AW    = 8
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  scma_entry_t       wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output scma_entry_t       rd_data
);

  scma_entry_t mem [DEPTH];
  scma_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[design/scma_merge.sv]
// ----------------------------------------------------------------------------
// scma_merge
// Compares the two list heads in row-major order and picks the smaller one,
// or adds both when the coordinates match; a lone head is passed through.
// ----------------------------------------------------------------------------
module scma_merge
  import scma_pkg::*;
(
  input  logic        has_a,
  input  logic        has_b,
  input  scma_entry_t head_a,
  input  scma_entry_t head_b,
  output scma_pick_t  pick
);

  logic                  a_first;
  logic                  b_first;
  logic [VALUE_BITS-1:0] sum;
  logic                  sum_ovf;

  assign a_first = (head_a.row < head_b.row) ||
                   ((head_a.row == head_b.row) && (head_a.col < head_b.col));
  assign b_first = (head_a.row > head_b.row) ||
                   ((head_a.row == head_b.row) && (head_a.col > head_b.col));
  assign sum     = head_a.value + head_b.value;
  // Signed overflow: operands agree in sign, sum does not
  assign sum_ovf = ~(head_a.value[VALUE_BITS-1] ^ head_b.value[VALUE_BITS-1]) &
                   (head_a.value[VALUE_BITS-1] ^ sum[VALUE_BITS-1]);

  always_comb begin
    pick = '0;
    if (has_a && has_b) begin
      pick.valid_res = 1'b1;
      if (a_first) begin
        pick.take_a = 1'b1;
        pick.entry  = head_a;
      end else if (b_first) begin
        pick.take_b = 1'b1;
        pick.entry  = head_b;
      end else begin
        pick.take_a      = 1'b1;
        pick.take_b      = 1'b1;
        pick.entry       = head_a;
        pick.entry.value = sum;
        pick.overflow    = sum_ovf;
      end
    end else if (has_a) begin
      pick.valid_res = 1'b1;
      pick.take_a    = 1'b1;
      pick.entry     = head_a;
    end else if (has_b) begin
      pick.valid_res = 1'b1;
      pick.take_b    = 1'b1;
      pick.entry     = head_b;
    end
  end

endmodule

[design/sparse_coo_matrix_add_unit.sv]
// ----------------------------------------------------------------------------
// sparse_coo_matrix_add_unit
// Row-major merge of two coordinate lists into their sum, one entry per pull.
// ----------------------------------------------------------------------------
// Clear and append beats produce no output beat. A pull first reads both
// list heads from their memories (registered read), then in the merge state
// compares, adds and advances the head pointers as the result is loaded
// into the output register. A pull waits in the merge state while the
// output register still holds an untaken beat, and no input beat is taken
// until it completes. The list memories start undefined and need no
// clearing pass after reset.
module sparse_coo_matrix_add_unit
  import scma_pkg::*;
#(
  parameter int MAX_ENTRIES = DEFAULT_MAX_ENTRIES
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [TDATA_BITS-1:0]     in_tdata,   // row, col, value, zero pad
  input  logic [IN_TUSER_BITS-1:0]  in_tuser,   // operation
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [TDATA_BITS-1:0]     out_tdata,  // out_row, out_col, out_value, zero pad
  output logic [OUT_TUSER_BITS-1:0] out_tuser,  // valid_res, overflow
  output logic                      out_tlast   // last
);

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_ENTRIES);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_MERGE = 1'b1;

  logic            state_r, state_nxt;
  logic [CW-1:0]   count_a_r, count_a_nxt;
  logic [CW-1:0]   count_b_r, count_b_nxt;
  logic [CW-1:0]   head_a_r, head_a_nxt;
  logic [CW-1:0]   head_b_r, head_b_nxt;
  logic            out_valid_r, out_valid_nxt;
  scma_entry_t     out_entry_r, out_entry_nxt;
  logic            out_res_r, out_res_nxt;
  logic            out_ovf_r, out_ovf_nxt;
  logic            out_last_r, out_last_nxt;

  logic            in_accept;
  scma_entry_t     in_entry;
  logic            wr_a, wr_b, rd_en;
  scma_entry_t     mem_a_q, mem_b_q;
  scma_pick_t      pick;
  logic            out_free;
  logic [CW-1:0]   head_a_adv, head_b_adv;

  assign in_tready = (state_r == ST_IDLE);
  assign in_accept = in_tvalid && in_tready;

  assign in_entry.row   = in_tdata[INDEX_BITS-1:0];
  assign in_entry.col   = in_tdata[2*INDEX_BITS-1:INDEX_BITS];
  assign in_entry.value = in_tdata[ENTRY_BITS-1:2*INDEX_BITS];

  scma_list_mem #(
    .DEPTH (MAX_ENTRIES),
    .AW    (AW)
  ) u_list_a (
    .clk     (clk),
    .wr_en   (wr_a),
    .wr_addr (count_a_r[AW-1:0]),
    .wr_data (in_entry),
    .rd_en   (rd_en),
    .rd_addr (head_a_r[AW-1:0]),
    .rd_data (mem_a_q)
  );

  scma_list_mem #(
    .DEPTH (MAX_ENTRIES),
    .AW    (AW)
  ) u_list_b (
    .clk     (clk),
    .wr_en   (wr_b),
    .wr_addr (count_b_r[AW-1:0]),
    .wr_data (in_entry),
    .rd_en   (rd_en),
    .rd_addr (head_b_r[AW-1:0]),
    .rd_data (mem_b_q)
  );

  scma_merge u_merge (
    .has_a  (head_a_r < count_a_r),
    .has_b  (head_b_r < count_b_r),
    .head_a (mem_a_q),
    .head_b (mem_b_q),
    .pick   (pick)
  );

  assign out_free   = !out_valid_r || out_tready;
  assign head_a_adv = head_a_r + CW'(pick.take_a);
  assign head_b_adv = head_b_r + CW'(pick.take_b);

  always_comb begin
    state_nxt     = state_r;
    count_a_nxt   = count_a_r;
    count_b_nxt   = count_b_r;
    head_a_nxt    = head_a_r;
    head_b_nxt    = head_b_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_entry_nxt = out_entry_r;
    out_res_nxt   = out_res_r;
    out_ovf_nxt   = out_ovf_r;
    out_last_nxt  = out_last_r;
    wr_a          = 1'b0;
    wr_b          = 1'b0;
    rd_en         = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          unique case (in_tuser)
            OP_CLEAR: begin
              count_a_nxt = '0;
              count_b_nxt = '0;
              head_a_nxt  = '0;
              head_b_nxt  = '0;
            end
            OP_APPEND_A: begin
              // drop the beat when the list is full
              if (count_a_r < MAX_COUNT) begin
                wr_a        = 1'b1;
                count_a_nxt = count_a_r + CW'(1);
              end
            end
            OP_APPEND_B: begin
              if (count_b_r < MAX_COUNT) begin
                wr_b        = 1'b1;
                count_b_nxt = count_b_r + CW'(1);
              end
            end
            OP_PULL: begin
              rd_en     = 1'b1;
              state_nxt = ST_MERGE;
            end
            default: begin
            end
          endcase
        end
      end
      ST_MERGE: begin
        // hold the read heads until the output register frees up
        if (out_free) begin
          head_a_nxt    = head_a_adv;
          head_b_nxt    = head_b_adv;
          out_valid_nxt = 1'b1;
          out_entry_nxt = pick.entry;
          out_res_nxt   = pick.valid_res;
          out_ovf_nxt   = pick.overflow;
          out_last_nxt  = pick.valid_res && (head_a_adv >= count_a_r) &&
                          (head_b_adv >= count_b_r);
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_a_r   <= '0;
      count_b_r   <= '0;
      head_a_r    <= '0;
      head_b_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_a_r   <= count_a_nxt;
      count_b_r   <= count_b_nxt;
      head_a_r    <= head_a_nxt;
      head_b_r    <= head_b_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_entry_r <= out_entry_nxt;
    out_res_r   <= out_res_nxt;
    out_ovf_r   <= out_ovf_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(TDATA_BITS - ENTRY_BITS)'(0), out_entry_r.value,
                       out_entry_r.col, out_entry_r.row};
  assign out_tuser  = {out_ovf_r, out_res_r};
  assign out_tlast  = out_last_r;

`include "sparse_coo_matrix_add_unit_assert.svh"

  `SCMA_ASSERT_RUN(a_head_within_count, (head_a_r <= count_a_r) && (head_b_r <= count_b_r), "head pointer passed list count")
  `SCMA_ASSERT_RUN(a_count_within_depth, (count_a_r <= MAX_COUNT) && (count_b_r <= MAX_COUNT), "list count exceeds depth")
  `SCMA_ASSERT_RUN(a_merge_loads_output, (state_r == ST_MERGE) && out_free |=> out_valid_r && (state_r == ST_IDLE), "merge step did not load the output register")
  `SCMA_ASSERT_RUN(a_exhausted_is_zero, out_valid_r && !out_res_r |-> (out_entry_r == '0) && !out_last_r && !out_ovf_r, "exhausted pull carries nonzero fields")
  `SCMA_ASSERT_ALL(a_reset_clears_output, !rst_n |=> !out_tvalid, "output beat valid after reset")

endmodule
